// ===== rtl/mbt_lpm_pkg.sv =====
// Shared types, sizes and codes for the multibit trie longest-prefix-match unit.
// No dependencies; the top level refers to it by scoped names.
package mbt_lpm_pkg;

  localparam int STRIDE     = 4;
  localparam int NODE_POOL  = 1024;
  localparam int LIST_DEPTH = 1024;
  localparam int HOP_BITS   = 16;

  localparam int FANOUT   = 1 << STRIDE;
  localparam int LEVELS   = (32 + STRIDE - 1) / STRIDE;
  localparam int EXT_W    = LEVELS * STRIDE;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int NODE_W   = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int NUSED_W  = $clog2(NODE_POOL + 1);
  localparam int LIST_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int LEN_W    = 6;
  localparam int STORE_AW = NODE_W + STRIDE;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ABSENT   = 2'd1;
  localparam logic [1:0] ST_NO_NODE  = 2'd2;
  localparam logic [1:0] ST_LIST_FUL = 2'd3;

  // One trie entry: best route ending here plus optional child node
  typedef struct packed {
    logic [HOP_BITS-1:0] hop;
    logic [LEN_W-1:0]    len;
    logic                valid;
    logic [NODE_W-1:0]   child;
  } entry_t;

  // One listed prefix
  typedef struct packed {
    logic [31:0]         addr;
    logic [LEN_W-1:0]    len;
    logic [HOP_BITS-1:0] hop;
  } route_t;

  // Address bits consumed at a level; zero bits pad below bit 0
  function automatic logic [STRIDE-1:0] slice_bits(input logic [31:0] a,
                                                   input logic [LVL_W-1:0] lvl);
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] sh;
    int               amt;
    ext = EXT_W'(a) << (EXT_W - 32);
    amt = EXT_W - (int'(lvl) + 1) * STRIDE;
    sh  = ext >> amt;
    return sh[STRIDE-1:0];
  endfunction

endpackage

// ===== rtl/multibit_trie_lpm_unit.sv =====
// Multibit trie longest-prefix-match unit: sequencer, entry store and prefix list.
// Depends on mbt_lpm_pkg.
//
//  channel | ports                                              | dir
//  --------+----------------------------------------------------+-----
//  in      | in_valid in_ready in_kind in_address in_prefix_len | in
//          | in_next_hop                                        |
//  out     | out_valid out_ready out_found out_hop_out          | out
//          | out_status                                         |
//
// One item at a time, all through a single-port-read entry store (one read per cycle).
// Lookup: a read state and an evaluate state per trie level visited, over at most LEVELS levels.
// Insert/remove: a read and a compare state per listed prefix scanned, then install (check, read
// and evaluate per level, read and write per expanded entry, and every entry of a new node cleared);
// a rebuild reinstalls every prefix. After reset all FANOUT root entries are cleared before items are taken.
// A finished result waits in the output register; a new item is taken once it is loaded.
module multibit_trie_lpm_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_address,
  input  logic [5:0]  in_prefix_len,
  input  logic [15:0] in_next_hop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [15:0] out_hop_out,
  output logic [1:0]  out_status
);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LK_RD, S_LK_EV, S_FD_RD, S_FD_EV, S_MISS, S_LIST_UPD,
    S_RM_RD, S_RM_WR, S_RB_CLR, S_RB_NEXT, S_RB_RD, S_RB_LD, S_IN_START,
    S_WK_CHK, S_WK_RD, S_WK_EV, S_NEW_CLR, S_EX_SET, S_EX_RD, S_EX_EV, S_DONE
  } state_t;

  localparam int HB = mbt_lpm_pkg::HOP_BITS;
  localparam int SD = mbt_lpm_pkg::STRIDE;

  state_t state_r;

  // Memories
  mbt_lpm_pkg::entry_t ent_mem [mbt_lpm_pkg::NODE_POOL * mbt_lpm_pkg::FANOUT];
  mbt_lpm_pkg::route_t pl_mem  [mbt_lpm_pkg::LIST_DEPTH];
  mbt_lpm_pkg::entry_t ent_q;
  mbt_lpm_pkg::route_t pl_q;

  logic                                en_we;
  logic [mbt_lpm_pkg::STORE_AW-1:0]    en_waddr, en_raddr;
  mbt_lpm_pkg::entry_t                 en_wdata;
  logic                                pl_we;
  logic [mbt_lpm_pkg::LIST_W-1:0]      pl_waddr, pl_raddr;
  mbt_lpm_pkg::route_t                 pl_wdata;

  // Item registers
  logic [1:0]                          kind_r;
  logic [31:0]                         addr_r;
  logic [mbt_lpm_pkg::LEN_W-1:0]       len_r;
  logic [HB-1:0]                       hop_r;
  // Install operands
  logic [31:0]                         ins_addr_r;
  logic [mbt_lpm_pkg::LEN_W-1:0]       ins_len_r;
  logic [HB-1:0]                       ins_hop_r;
  // Walk state
  logic [mbt_lpm_pkg::NODE_W-1:0]      node_r;
  logic [mbt_lpm_pkg::LVL_W-1:0]       lvl_r, d_r;
  logic [SD-1:0]                       f_r, fend_r;
  logic [mbt_lpm_pkg::CNT_W-1:0]       idx_r, rb_i_r, count_r;
  logic [mbt_lpm_pkg::NUSED_W-1:0]     nodes_used_r;
  logic                                rb_mode_r;
  logic [HB-1:0]                       dflt_hop_r;
  logic                                dflt_v_r;
  // Result accumulation and output
  logic                                res_found_r;
  logic [HB-1:0]                       res_hop_r;
  logic [1:0]                          res_status_r;
  logic                                out_valid_r, out_found_r;
  logic [15:0]                         out_hop_r;
  logic [1:0]                          out_status_r;

  logic [mbt_lpm_pkg::LEN_W-1:0]       in_len_sat;
  logic                                pool_full;
  logic [mbt_lpm_pkg::CNT_W-1:0]       last_idx;
  logic [SD:0]                         rem_bits;
  logic [SD-1:0]                       ex_mask, ex_slice;
  logic [mbt_lpm_pkg::LEN_W-1:0]       len_m1;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_hop_out = out_hop_r;
  assign out_status  = out_status_r;

  assign in_len_sat = (in_prefix_len > 6'd32) ? 6'd32 : in_prefix_len;
  assign pool_full  = (nodes_used_r >= mbt_lpm_pkg::NUSED_W'(mbt_lpm_pkg::NODE_POOL));
  assign last_idx   = count_r - mbt_lpm_pkg::CNT_W'(1);
  assign len_m1     = ins_len_r - mbt_lpm_pkg::LEN_W'(1);

  // Expansion range at the last level
  assign rem_bits = (SD + 1)'(ins_len_r - mbt_lpm_pkg::LEN_W'(int'(d_r) * SD));
  assign ex_mask  = SD'(({{SD{1'b0}}, 1'b1} << (SD - int'(rem_bits))) - 1);
  assign ex_slice = mbt_lpm_pkg::slice_bits(ins_addr_r, d_r);

  // Memory port controls
  always_comb begin
    en_we    = 1'b0;
    en_waddr = '0;
    en_wdata = '0;
    en_raddr = '0;
    pl_we    = 1'b0;
    pl_waddr = '0;
    pl_wdata = '0;
    pl_raddr = '0;
    unique case (state_r) inside
      S_INIT, S_RB_CLR: begin
        en_we    = 1'b1;
        en_waddr = {{mbt_lpm_pkg::NODE_W{1'b0}}, f_r};
      end
      S_NEW_CLR: begin
        en_we    = 1'b1;
        en_waddr = {node_r, f_r};
      end
      S_LK_RD: en_raddr = {node_r, mbt_lpm_pkg::slice_bits(addr_r, lvl_r)};
      S_WK_RD: en_raddr = {node_r, mbt_lpm_pkg::slice_bits(ins_addr_r, lvl_r)};
      S_EX_RD: en_raddr = {node_r, f_r};
      S_WK_EV: begin
        en_waddr = {node_r, mbt_lpm_pkg::slice_bits(ins_addr_r, lvl_r)};
        en_wdata = ent_q;
        en_wdata.child = nodes_used_r[mbt_lpm_pkg::NODE_W-1:0];
        en_we    = (ent_q.child == '0) && !pool_full;
      end
      S_EX_EV: begin
        en_waddr = {node_r, f_r};
        en_wdata.hop   = ins_hop_r;
        en_wdata.len   = ins_len_r;
        en_wdata.valid = 1'b1;
        en_wdata.child = ent_q.child;
        en_we    = !ent_q.valid || (ins_len_r >= ent_q.len);
      end
      S_FD_RD: pl_raddr = idx_r[mbt_lpm_pkg::LIST_W-1:0];
      S_RM_RD: pl_raddr = last_idx[mbt_lpm_pkg::LIST_W-1:0];
      S_RB_RD: pl_raddr = rb_i_r[mbt_lpm_pkg::LIST_W-1:0];
      S_LIST_UPD: begin
        pl_we    = 1'b1;
        pl_waddr = idx_r[mbt_lpm_pkg::LIST_W-1:0];
        pl_wdata = '{addr: addr_r, len: len_r, hop: hop_r};
      end
      S_MISS: begin
        pl_we    = (kind_r == mbt_lpm_pkg::KIND_INSERT) &&
                   (count_r < mbt_lpm_pkg::CNT_W'(mbt_lpm_pkg::LIST_DEPTH));
        pl_waddr = count_r[mbt_lpm_pkg::LIST_W-1:0];
        pl_wdata = '{addr: addr_r, len: len_r, hop: hop_r};
      end
      S_RM_WR: begin
        pl_we    = 1'b1;
        pl_waddr = idx_r[mbt_lpm_pkg::LIST_W-1:0];
        pl_wdata = pl_q;
      end
      default: ;
    endcase
  end

  // Entry store and prefix list, registered reads
  always_ff @(posedge clk) begin
    if (en_we) ent_mem[en_waddr] <= en_wdata;
    ent_q <= ent_mem[en_raddr];
    if (pl_we) pl_mem[pl_waddr] <= pl_wdata;
    pl_q <= pl_mem[pl_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      f_r          <= '0;
      count_r      <= '0;
      nodes_used_r <= mbt_lpm_pkg::NUSED_W'(1);
      dflt_hop_r   <= '0;
      dflt_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      rb_mode_r    <= 1'b0;
    end else begin
      // drain the output register unless a new result is loaded this cycle
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_INIT: begin
          f_r <= f_r + SD'(1);
          if (f_r == '1) state_r <= S_IDLE;
        end

        S_IDLE: begin
          if (in_valid) begin
            kind_r       <= in_kind;
            addr_r       <= in_address;
            len_r        <= in_len_sat;
            hop_r        <= in_next_hop[HB-1:0];
            res_found_r  <= (in_kind == mbt_lpm_pkg::KIND_LOOKUP) && dflt_v_r;
            res_hop_r    <= ((in_kind == mbt_lpm_pkg::KIND_LOOKUP) && dflt_v_r) ?
                            dflt_hop_r : '0;
            res_status_r <= mbt_lpm_pkg::ST_OK;
            idx_r        <= '0;
            node_r       <= '0;
            lvl_r        <= '0;
            rb_mode_r    <= 1'b0;
            unique case (in_kind) inside
              mbt_lpm_pkg::KIND_LOOKUP: begin
                state_r <= S_LK_RD;
              end
              mbt_lpm_pkg::KIND_INSERT, mbt_lpm_pkg::KIND_REMOVE: begin
                state_r <= (count_r == '0) ? S_MISS : S_FD_RD;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end

        // Lookup: read then evaluate, one level per pass
        S_LK_RD: state_r <= S_LK_EV;
        S_LK_EV: begin
          if (ent_q.valid) begin
            res_found_r <= 1'b1;
            res_hop_r   <= ent_q.hop;
          end
          if (ent_q.child == '0 ||
              lvl_r == mbt_lpm_pkg::LVL_W'(mbt_lpm_pkg::LEVELS - 1)) begin
            state_r <= S_DONE;
          end else begin
            node_r  <= ent_q.child;
            lvl_r   <= lvl_r + mbt_lpm_pkg::LVL_W'(1);
            state_r <= S_LK_RD;
          end
        end

        // Scan the list for the prefix
        S_FD_RD: state_r <= S_FD_EV;
        S_FD_EV: begin
          if (pl_q.addr == addr_r && pl_q.len == len_r) begin
            state_r <= (kind_r == mbt_lpm_pkg::KIND_INSERT) ? S_LIST_UPD : S_RM_RD;
          end else if (idx_r == last_idx) begin
            state_r <= S_MISS;
          end else begin
            idx_r   <= idx_r + mbt_lpm_pkg::CNT_W'(1);
            state_r <= S_FD_RD;
          end
        end

        S_MISS: begin
          if (kind_r != mbt_lpm_pkg::KIND_INSERT) begin
            res_status_r <= mbt_lpm_pkg::ST_ABSENT;
            state_r      <= S_DONE;
          end else if (count_r >= mbt_lpm_pkg::CNT_W'(mbt_lpm_pkg::LIST_DEPTH)) begin
            res_status_r <= mbt_lpm_pkg::ST_LIST_FUL;
            state_r      <= S_DONE;
          end else begin
            // append and install just this prefix
            count_r    <= count_r + mbt_lpm_pkg::CNT_W'(1);
            ins_addr_r <= addr_r;
            ins_len_r  <= len_r;
            ins_hop_r  <= hop_r;
            state_r    <= S_IN_START;
          end
        end

        S_LIST_UPD: begin
          f_r     <= '0;
          state_r <= S_RB_CLR;
        end

        S_RM_RD: state_r <= S_RM_WR;
        S_RM_WR: begin
          count_r <= last_idx;
          f_r     <= '0;
          state_r <= S_RB_CLR;
        end

        // Rebuild: clear root, then reinstall every listed prefix
        S_RB_CLR: begin
          f_r <= f_r + SD'(1);
          if (f_r == '1) begin
            nodes_used_r <= mbt_lpm_pkg::NUSED_W'(1);
            dflt_v_r     <= 1'b0;
            rb_i_r       <= '0;
            rb_mode_r    <= 1'b1;
            state_r      <= S_RB_NEXT;
          end
        end
        S_RB_NEXT: state_r <= (rb_i_r < count_r) ? S_RB_RD : S_DONE;
        S_RB_RD:   state_r <= S_RB_LD;
        S_RB_LD: begin
          ins_addr_r <= pl_q.addr;
          ins_len_r  <= pl_q.len;
          ins_hop_r  <= pl_q.hop;
          state_r    <= S_IN_START;
        end

        // Install one route
        S_IN_START: begin
          node_r <= '0;
          lvl_r  <= '0;
          d_r    <= mbt_lpm_pkg::LVL_W'(len_m1 / mbt_lpm_pkg::LEN_W'(SD));
          if (ins_len_r == '0) begin
            dflt_hop_r <= ins_hop_r;
            dflt_v_r   <= 1'b1;
            if (rb_mode_r) begin
              rb_i_r  <= rb_i_r + mbt_lpm_pkg::CNT_W'(1);
              state_r <= S_RB_NEXT;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_WK_CHK;
          end
        end
        S_WK_CHK: state_r <= (lvl_r == d_r) ? S_EX_SET : S_WK_RD;
        S_WK_RD:  state_r <= S_WK_EV;
        S_WK_EV: begin
          if (ent_q.child != '0) begin
            node_r  <= ent_q.child;
            lvl_r   <= lvl_r + mbt_lpm_pkg::LVL_W'(1);
            state_r <= S_WK_CHK;
          end else if (pool_full) begin
            res_status_r <= mbt_lpm_pkg::ST_NO_NODE;
            state_r      <= S_DONE;
          end else begin
            // allocate a node, then clear its entries
            node_r       <= nodes_used_r[mbt_lpm_pkg::NODE_W-1:0];
            nodes_used_r <= nodes_used_r + mbt_lpm_pkg::NUSED_W'(1);
            f_r          <= '0;
            state_r      <= S_NEW_CLR;
          end
        end
        S_NEW_CLR: begin
          f_r <= f_r + SD'(1);
          if (f_r == '1) begin
            lvl_r   <= lvl_r + mbt_lpm_pkg::LVL_W'(1);
            state_r <= S_WK_CHK;
          end
        end
        S_EX_SET: begin
          f_r     <= ex_slice & ~ex_mask;
          fend_r  <= ex_slice | ex_mask;
          state_r <= S_EX_RD;
        end
        S_EX_RD: state_r <= S_EX_EV;
        S_EX_EV: begin
          if (f_r != fend_r) begin
            f_r     <= f_r + SD'(1);
            state_r <= S_EX_RD;
          end else if (rb_mode_r) begin
            rb_i_r  <= rb_i_r + mbt_lpm_pkg::CNT_W'(1);
            state_r <= S_RB_NEXT;
          end else begin
            state_r <= S_DONE;
          end
        end

        // Hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= res_found_r;
            out_hop_r    <= 16'(res_hop_r);
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= mbt_lpm_pkg::NUSED_W'(mbt_lpm_pkg::NODE_POOL))
    else $error("node count beyond pool");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= mbt_lpm_pkg::CNT_W'(mbt_lpm_pkg::LIST_DEPTH))
    else $error("prefix count beyond list depth");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while busy");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_hop_out) && $stable(out_status))
    else $error("pending result changed");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the multibit trie longest-prefix-match unit.
// Depends on mbt_lpm_pkg and multibit_trie_lpm_unit; a scoreboard class predicts results.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] KIND_NOP = 2'd3;

  typedef struct packed {
    logic        found;
    logic [15:0] hop;
    logic [1:0]  status;
  } lpm_result_t;

  // Route table predictor plus queue of expected results
  class lpm_scoreboard;
    mbt_lpm_pkg::entry_t cells[mbt_lpm_pkg::NODE_POOL*mbt_lpm_pkg::FANOUT];
    mbt_lpm_pkg::route_t routes[mbt_lpm_pkg::LIST_DEPTH];
    int unsigned route_cnt;
    int unsigned node_cnt;
    logic [15:0] dflt_hop;
    bit          dflt_ok;
    lpm_result_t pending[$];
    int unsigned n_bad;

    function new();
      foreach (cells[i]) cells[i] = '0;
      node_cnt = 1; route_cnt = 0; dflt_hop = 0; dflt_ok = 0; n_bad = 0;
    endfunction

    function automatic int unsigned nibble(logic [31:0] a, int lvl);
      return (a >> (32 - (lvl + 1) * mbt_lpm_pkg::STRIDE)) & (mbt_lpm_pkg::FANOUT - 1);
    endfunction

    function automatic bit add_route(logic [31:0] a, int unsigned len, logic [15:0] hop);
      int unsigned node, d, r, base, span, idx;
      node = 0;
      if (len == 0) begin
        dflt_hop = hop; dflt_ok = 1;
        return 1;
      end
      d = (len - 1) / mbt_lpm_pkg::STRIDE;
      for (int j = 0; j < d; j++) begin
        idx = node * mbt_lpm_pkg::FANOUT + nibble(a, j);
        if (cells[idx].child == 0) begin
          if (node_cnt >= mbt_lpm_pkg::NODE_POOL) return 0;
          cells[idx].child = mbt_lpm_pkg::NODE_W'(node_cnt);
          node_cnt++;
        end
        node = cells[idx].child;
      end
      r = len - d * mbt_lpm_pkg::STRIDE;
      span = 1 << (mbt_lpm_pkg::STRIDE - r);
      base = (nibble(a, d) >> (mbt_lpm_pkg::STRIDE - r)) << (mbt_lpm_pkg::STRIDE - r);
      for (int f = 0; f < span; f++) begin
        idx = node * mbt_lpm_pkg::FANOUT + base + f;
        if (!cells[idx].valid || len >= cells[idx].len) begin
          cells[idx].valid = 1;
          cells[idx].len = mbt_lpm_pkg::LEN_W'(len);
          cells[idx].hop = hop;
        end
      end
      return 1;
    endfunction

    function automatic bit regrow();
      foreach (cells[i]) cells[i] = '0;
      node_cnt = 1; dflt_ok = 0;
      for (int i = 0; i < route_cnt; i++)
        if (!add_route(routes[i].addr, routes[i].len, routes[i].hop)) return 0;
      return 1;
    endfunction

    function automatic int unsigned locate(logic [31:0] a, int unsigned len);
      for (int i = 0; i < route_cnt; i++)
        if (routes[i].addr == a && routes[i].len == len) return i;
      return route_cnt;
    endfunction

    // Note an accepted item and queue the result it causes
    function void note_item(logic [1:0] kind, logic [31:0] a, logic [5:0] plen,
                            logic [15:0] hop);
      lpm_result_t res;
      int unsigned len, i, node, idx;
      res = '0;
      len = (plen > 32) ? 32 : plen;
      if (kind == mbt_lpm_pkg::KIND_LOOKUP) begin
        node = 0;
        if (dflt_ok) begin res.found = 1; res.hop = dflt_hop; end
        for (int lvl = 0; lvl < mbt_lpm_pkg::LEVELS; lvl++) begin
          idx = node * mbt_lpm_pkg::FANOUT + nibble(a, lvl);
          if (cells[idx].valid) begin res.found = 1; res.hop = cells[idx].hop; end
          if (cells[idx].child == 0) break;
          node = cells[idx].child;
        end
      end else if (kind == mbt_lpm_pkg::KIND_INSERT) begin
        i = locate(a, len);
        if (i < route_cnt) begin
          routes[i].hop = hop;
          res.status = regrow() ? mbt_lpm_pkg::ST_OK : mbt_lpm_pkg::ST_NO_NODE;
        end else if (route_cnt >= mbt_lpm_pkg::LIST_DEPTH) begin
          res.status = mbt_lpm_pkg::ST_LIST_FUL;
        end else begin
          routes[route_cnt] = '{addr: a, len: mbt_lpm_pkg::LEN_W'(len), hop: hop};
          route_cnt++;
          res.status = add_route(a, len, hop) ? mbt_lpm_pkg::ST_OK : mbt_lpm_pkg::ST_NO_NODE;
        end
      end else if (kind == mbt_lpm_pkg::KIND_REMOVE) begin
        i = locate(a, len);
        if (i < route_cnt) begin
          routes[i] = routes[route_cnt-1];
          route_cnt--;
          res.status = regrow() ? mbt_lpm_pkg::ST_OK : mbt_lpm_pkg::ST_NO_NODE;
        end else begin
          res.status = mbt_lpm_pkg::ST_ABSENT;
        end
      end
      pending.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(lpm_result_t got);
      lpm_result_t want;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch: expected found=%0d hop=%h status=%0d, %s",
                   want.found, want.hop, want.status,
                   $sformatf("got found=%0d hop=%h status=%0d",
                             got.found, got.hop, got.status));
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  in_kind = 0;
  logic [31:0] in_address = 0;
  logic [5:0]  in_prefix_len = 0;
  logic [15:0] in_next_hop = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_found;
  logic [15:0] out_hop_out;
  logic [1:0]  out_status;

  lpm_scoreboard sb = new();
  bit            hold_off = 0;
  bit            stim_done = 0;
  logic [31:0]   known_addr[$];
  logic [5:0]    known_len[$];

  multibit_trie_lpm_unit u_top (.*);

  always #5 clk = ~clk;

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_item(in_kind, in_address, in_prefix_len, in_next_hop);
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_found, out_hop_out, out_status});
  end

  // Receiver stall pattern, with a long hold-off whenever one is requested
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      mode = ($urandom_range(0, 199) < 4) ? 1 - mode : mode;
      if (hold_off) out_ready <= 0;
      else if (mode == 0) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Offer one item from a falling edge; return at the falling edge after acceptance
  // with valid still high, so a following item keeps the channel busy
  task automatic send_item(logic [1:0] kind, logic [31:0] a, logic [5:0] plen,
                           logic [15:0] hop);
    in_valid <= 1; in_kind <= kind; in_address <= a;
    in_prefix_len <= plen; in_next_hop <= hop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid at the current falling edge
  task automatic go_idle();
    in_valid <= 0;
  endtask

  // Prefix drawn mostly from already known routes, sometimes fresh
  task automatic send_random();
    int          k, pick;
    logic [31:0] a;
    logic [5:0]  plen;
    k = $urandom_range(0, 99);
    a = $urandom;
    plen = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
    if (known_addr.size() > 0 && $urandom_range(0, 2) != 0) begin
      pick = $urandom_range(0, known_addr.size() - 1);
      if (k < 45) a = known_addr[pick] ^ ($urandom_range(0, 1) ? $urandom_range(0, 255) : 0);
      else begin a = known_addr[pick]; plen = known_len[pick]; end
    end
    if (k < 40) send_item(mbt_lpm_pkg::KIND_LOOKUP, a, plen, $urandom);
    else if (k < 80) begin
      if (known_addr.size() < 400 && plen <= 24) begin
        known_addr.push_back(a); known_len.push_back(plen);
      end
      send_item(mbt_lpm_pkg::KIND_INSERT, a, plen, $urandom);
    end else if (k < 97) send_item(mbt_lpm_pkg::KIND_REMOVE, a, plen, $urandom);
    else send_item(KIND_NOP, a, plen, $urandom);
  endtask

  task automatic drain();
    go_idle();
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Directed: extremes, every kind, default route, update, absent remove
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'h0, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'h0, 6'd0, 16'hFFFF);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'h0);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h1234);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 6'd63, 16'h5678);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'hFF00_0000, 6'd8, 16'hAAAA);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'hF000_0000, 6'd1, 16'h5555);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'hFFF0_0000, 6'd13, 16'h0001);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'hFFF8_1234, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'hFF01_0000, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'h8000_0000, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'hFF00_0000, 6'd8, 16'hBBBB);
    send_item(mbt_lpm_pkg::KIND_INSERT, 32'hFF00_0001, 6'd8, 16'hCCCC);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'hFF12_3456, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_REMOVE, 32'h1234_5678, 6'd20, 16'h0);
    send_item(mbt_lpm_pkg::KIND_REMOVE, 32'hFF00_0000, 6'd8, 16'h0);
    send_item(KIND_NOP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'hFF12_3456, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_REMOVE, 32'h0, 6'd0, 16'h0);
    send_item(mbt_lpm_pkg::KIND_LOOKUP, 32'h0123_4567, 6'd0, 16'h0);
    // Random bursts with gaps
    for (int n = 0; n < 850; ) begin
      int burst;
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin send_random(); n++; end
      if ($urandom_range(0, 1)) begin
        go_idle();
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      if (n > 300 && n < 321) begin
        // Long receiver hold-off while items keep coming
        hold_off = 1;
        fork
          begin repeat (400) @(negedge clk); hold_off = 0; end
          repeat (6) send_random();
        join
        n += 6;
        drain();
      end
    end
    drain();
    repeat (200) @(negedge clk);
    if (sb.n_bad == 0 && sb.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #1s;
    $display("FAIL");
    $finish;
  end
endmodule
